// ===== rtl/core/rpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types, codes and sizes of the reference counted page frame allocator.
// ----------------------------------------------------------------------------
package rpfa_pkg;

	localparam int PAGE_W            = 15;
	localparam int COUNT_W           = 8;
	localparam int PAGE_LIMIT        = 32768;
	localparam int DEFAULT_NUM_PAGES = 32768;
	localparam int APB_ADDR_W        = 3;
	localparam int APB_DATA_W        = 32;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_SEED   = 2'd2,
		OP_ADJUST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                        operation;
		logic [PAGE_W-1:0]          page;
		logic signed [COUNT_W-1:0]  delta;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [PAGE_W-1:0]          granted_page;
		logic signed [COUNT_W-1:0]  count;
		logic                       released;
	} rsp_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		op_t                        op;
		logic [PAGE_W-1:0]          page;
		logic signed [COUNT_W-1:0]  delta;
		logic                       out_of_range;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_READ  = 2'd1,
		BK_WRITE = 2'd2
	} back_state_t;

endpackage

// ===== rtl/core/rpfa_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register queue
// Two-entry first-in first-out queue used for commands and for results.
// ----------------------------------------------------------------------------
module rpfa_fifo
	import rpfa_pkg::*;
#(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/rpfa_front.sv =====
// ----------------------------------------------------------------------------
// Allocator front end
// Holds the configuration register, range-checks requests and queues them.
// ----------------------------------------------------------------------------
module rpfa_front
	import rpfa_pkg::*;
#(
	parameter int NUM_PAGES = DEFAULT_NUM_PAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  push,
	input  req_t                  request,
	input  logic                  hold,
	output logic                  full,
	output cmd_t                  cmd,
	output logic                  cmd_valid,
	input  logic                  cmd_pop
);

	localparam logic REG_FIRST_PAGE = 1'b0;
	localparam logic [PAGE_W:0] LIMIT =
		(PAGE_W+1)'((NUM_PAGES > PAGE_LIMIT) ? PAGE_LIMIT : NUM_PAGES);

	logic [PAGE_W-1:0] first_page_q;
	logic              q_full;
	logic              q_empty;
	logic              in_store;
	logic              below_first;
	logic [$bits(cmd_t)-1:0] q_dout;
	cmd_t              cmd_new;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FIRST_PAGE)) begin
			first_page_q <= pwdata[PAGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FIRST_PAGE) begin
			prdata = APB_DATA_W'(first_page_q);
		end
	end

	// Classification of the incoming request.
	assign in_store    = ({1'b0, request.page} < LIMIT);
	assign below_first = (request.page < first_page_q);

	always_comb begin
		cmd_new.op    = request.operation;
		cmd_new.page  = request.page;
		cmd_new.delta = request.delta;
		unique case (request.operation) inside
			OP_ALLOC:         cmd_new.out_of_range = 1'b0;
			OP_FREE, OP_SEED: cmd_new.out_of_range = below_first || !in_store;
			OP_ADJUST:        cmd_new.out_of_range = !in_store;
		endcase
	end

	assign full = q_full || hold;

	rpfa_fifo #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !hold),
		.din    (cmd_new),
		.full   (q_full),
		.pop    (cmd_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign cmd       = cmd_t'(q_dout);
	assign cmd_valid = !q_empty;

endmodule

// ===== rtl/core/rpfa_back.sv =====
// ----------------------------------------------------------------------------
// Allocator back end
// Owns the count and link memories; reads, then writes, one command at a time.
// ----------------------------------------------------------------------------
module rpfa_back
	import rpfa_pkg::*;
#(
	parameter int NUM_PAGES = DEFAULT_NUM_PAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  logic rsp_full,
	output logic rsp_push,
	output rsp_t rsp,
	output logic clearing
);

	localparam int DEPTH = (NUM_PAGES > PAGE_LIMIT) ? PAGE_LIMIT : NUM_PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	// Memories: the count store is swept to zero after reset, the link store
	// keeps the next page plus a bit that says whether that link is real.
	logic signed [COUNT_W-1:0] cnt_mem  [DEPTH];
	logic [AW:0]               link_mem [DEPTH];

	back_state_t               state_q;
	back_state_t               state_d;
	logic [AW-1:0]             clr_q;
	logic [AW-1:0]             head_q;
	logic                      nonempty_q;
	cmd_t                      cmd_q;
	logic signed [COUNT_W-1:0] cnt_rd_q;
	logic [AW:0]               link_rd_q;

	logic                      start;
	logic                      cnt_we;
	logic [AW-1:0]             cnt_wa;
	logic signed [COUNT_W-1:0] cnt_wd;
	logic                      link_we;
	logic                      head_we;
	logic [AW-1:0]             head_d;
	logic                      nonempty_d;
	logic signed [COUNT_W-1:0] new_cnt;

	assign start = (state_q == BK_READ) && cmd_valid && !rsp_full;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_q == LAST) state_d = BK_READ;
			BK_READ:  if (start) state_d = BK_WRITE;
			BK_WRITE: state_d = BK_READ;
			default:  state_d = BK_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			nonempty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (head_we) begin
				head_q     <= head_d;
				nonempty_q <= nonempty_d;
			end
		end
	end

	// Outputs and the write phase of the current command.
	always_comb begin
		cmd_pop    = start;
		clearing   = (state_q == BK_CLEAR);
		rsp_push   = (state_q == BK_WRITE);
		cnt_we     = 1'b0;
		cnt_wa     = cmd_q.page[AW-1:0];
		cnt_wd     = '0;
		link_we    = 1'b0;
		head_we    = 1'b0;
		head_d     = head_q;
		nonempty_d = nonempty_q;
		new_cnt    = '0;
		rsp.status       = ST_OK;
		rsp.granted_page = '0;
		rsp.count        = '0;
		rsp.released     = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
			end
			BK_WRITE: begin
				unique case (cmd_q.op) inside
					OP_ALLOC: begin
						if (!nonempty_q) begin
							rsp.status = ST_OOM;
						end else begin
							rsp.granted_page = PAGE_W'(head_q);
							rsp.count        = COUNT_W'(1);
							cnt_we           = 1'b1;
							cnt_wa           = head_q;
							cnt_wd           = COUNT_W'(1);
							head_we          = 1'b1;
							head_d           = link_rd_q[AW-1:0];
							nonempty_d       = link_rd_q[AW];
						end
					end
					OP_FREE, OP_SEED: begin
						if (cmd_q.out_of_range) begin
							rsp.status = ST_RANGE;
						end else begin
							// Seed sets the count to one first, so it always lands on zero.
							new_cnt   = (cmd_q.op == OP_SEED) ? '0 : cnt_rd_q - COUNT_W'(1);
							cnt_we    = 1'b1;
							cnt_wd    = new_cnt;
							rsp.count = new_cnt;
							if (new_cnt == '0) begin
								link_we      = 1'b1;
								head_we      = 1'b1;
								head_d       = cmd_q.page[AW-1:0];
								nonempty_d   = 1'b1;
								rsp.released = 1'b1;
							end
						end
					end
					OP_ADJUST: begin
						if (cmd_q.out_of_range) begin
							rsp.status = ST_RANGE;
						end else begin
							new_cnt   = cnt_rd_q + cmd_q.delta;
							cnt_we    = 1'b1;
							cnt_wd    = new_cnt;
							rsp.count = new_cnt;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Command register for the write phase.
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
		end
	end

	// Count memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cmd.page[AW-1:0]];
	end

	// Link memory: the read always looks at the current head.
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[cmd_q.page[AW-1:0]] <= {nonempty_q, head_q};
		end
		link_rd_q <= link_mem[head_q];
	end

endmodule

// ===== rtl/core/refcounted_page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Reference counted page frame allocator
// LIFO free list of page numbers with a signed 8-bit reference count per page.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// request   in         push / full                  req_t: operation, page, delta
// result    out        pop / empty                  rsp_t: status, granted_page,
//                                                   count, released
// config    in/out     psel, penable, pwrite, pready first_page at byte address 0
//
// In the back end the read state reads the count memory and the link
// memory, and the write state after it writes them and moves the head.
// That read-then-write turn on the synchronous memories lets the back end
// take a new request only once the last one is written. After reset the
// count memory is swept to zero, one entry per cycle, over min(NUM_PAGES,
// 32768) entries; full stays high for that time. Two-entry command and
// result queues let the request and result sides stall independently; a
// held pop stalls the back end only once the result queue is full.
//
module refcounted_page_frame_allocator_top
	import rpfa_pkg::*;
#(
	parameter int NUM_PAGES = DEFAULT_NUM_PAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  req_t                  request,
	output logic                  empty,
	input  logic                  pop,
	output rsp_t                  result
);

	cmd_t                    cmd;
	logic                    cmd_valid;
	logic                    cmd_pop;
	logic                    rsp_full;
	logic                    rsp_push;
	rsp_t                    rsp_in;
	logic                    clearing;
	logic [$bits(rsp_t)-1:0] rsp_dout;

	// The front end owns the configuration register and the command queue.
	rpfa_front #(
		.NUM_PAGES (NUM_PAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.push      (push),
		.request   (request),
		.hold      (clearing),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// The back end starts a command only when the result queue has room,
	// so its result can always be pushed in the write cycle.
	rpfa_back #(
		.NUM_PAGES (NUM_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (rsp_in),
		.clearing  (clearing)
	);

	// Result queue; its head is what the consumer sees.
	rpfa_fifo #(
		.WIDTH ($bits(rsp_t))
	) u_rsp_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.din    (rsp_in),
		.full   (rsp_full),
		.pop    (pop),
		.dout   (rsp_dout),
		.empty  (empty)
	);

	assign result = rsp_t'(rsp_dout);

	// A result is never offered to a full result queue.
	a_rsp_room: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |-> !rsp_full)
		else $error("result pushed into a full result queue");

	// The back end takes a command only when one is waiting.
	a_cmd_avail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from an empty command queue");

	// No request is taken while the count memory is being swept.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("request side open during the clearing pass");

	// A page is released only by a successful free or seed that reached zero.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_push && rsp_in.released) |-> (rsp_in.status == ST_OK && rsp_in.count == '0))
		else $error("page released with a nonzero count");

endmodule

// ===== sim/tb_refcounted_page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate, free, seed and adjust requests through the request queue,
// predicts results from a private copy of the free list, the reference counts
// and first_page or takes them from directed rows, compares field by field.
// ----------------------------------------------------------------------------
module tb_refcounted_page_frame_allocator_top;
	import rpfa_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 200;
	localparam int HELD_MAX      = 64;
	localparam int PAGE_WINDOW   = 24;
	localparam int NUM_DIRECTED  = 25;
	// The clearing pass and the rest of the run stay far inside this limit
	// even with the slowest sender and receiver patterns.
	localparam int RUN_LIMIT     = 5_000_000;

	// first_page is register 0 and every register fits in 32 bits.
	localparam logic [APB_ADDR_W-1:0] FIRST_PAGE_ADDR = '0;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push    = 1'b0;
	logic                  full;
	req_t                  request = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	rsp_t                  result;

	refcounted_page_frame_allocator_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Private copy of the allocator state. The link store is only ever read
	// for a page that was pushed, so its initial contents never matter.
	logic signed [COUNT_W-1:0] model_count   [PAGE_LIMIT];
	logic [PAGE_W-1:0]         model_link    [PAGE_LIMIT];
	logic                      model_link_ok [PAGE_LIMIT];
	logic [PAGE_W-1:0]         model_head;
	logic                      model_has_free;
	logic [PAGE_W-1:0]         model_first_page;

	rsp_t              expected_results [$];
	logic [PAGE_W-1:0] held_pages [$];
	int                error_count = 0;
	int                burst_left  = 0;

	// Directed rows. Where typed is set, want is the result read straight off
	// the behavior; otherwise the predictor supplies the expectation.
	typedef struct {
		op_t                       op;
		logic [PAGE_W-1:0]         page;
		logic signed [COUNT_W-1:0] delta;
		bit                        typed;
		rsp_t                      want;
	} step_row_t;

	step_row_t directed_steps [NUM_DIRECTED] = '{
		// Allocate from the empty list right after reset.
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b1, '{ST_OOM,   15'd0,     8'sd0,   1'b0}},
		// Free of a page whose count is 0 wraps to -1 and is not listed.
		'{OP_FREE,   15'd32767, 8'sd0,   1'b1, '{ST_OK,    15'd0,     8'shFF,  1'b0}},
		// Free and seed below first_page (16) are rejected.
		'{OP_FREE,   15'd3,     8'sd0,   1'b1, '{ST_RANGE, 15'd0,     8'sd0,   1'b0}},
		'{OP_SEED,   15'd15,    8'sd0,   1'b1, '{ST_RANGE, 15'd0,     8'sd0,   1'b0}},
		'{OP_SEED,   15'd16,    8'sd0,   1'b1, '{ST_OK,    15'd0,     8'sd0,   1'b1}},
		'{OP_SEED,   15'd32767, 8'sd0,   1'b1, '{ST_OK,    15'd0,     8'sd0,   1'b1}},
		// The list hands pages back last in, first out, then runs dry.
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b1, '{ST_OK,    15'd32767, 8'sd1,   1'b0}},
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b1, '{ST_OK,    15'd16,    8'sd1,   1'b0}},
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b1, '{ST_OOM,   15'd0,     8'sd0,   1'b0}},
		// Adjust below first_page is allowed and wraps at both ends.
		'{OP_ADJUST, 15'd0,     8'sd127, 1'b1, '{ST_OK,    15'd0,     8'sd127, 1'b0}},
		'{OP_ADJUST, 15'd0,     8'sd1,   1'b1, '{ST_OK,    15'd0,     8'sh80,  1'b0}},
		'{OP_ADJUST, 15'd0,     8'sh80,  1'b1, '{ST_OK,    15'd0,     8'sd0,   1'b0}},
		'{OP_ADJUST, 15'd16,    -8'sd1,  1'b0, '0},
		'{OP_FREE,   15'd16,    8'sd0,   1'b0, '0},
		'{OP_ADJUST, 15'd16,    8'sd2,   1'b0, '0},
		'{OP_FREE,   15'd16,    8'sd0,   1'b0, '0},
		'{OP_ADJUST, 15'd32767, 8'sd2,   1'b0, '0},
		'{OP_FREE,   15'd32767, 8'sd0,   1'b0, '0},
		'{OP_SEED,   15'd32767, 8'sd0,   1'b0, '0},
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b0, '0},
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b0, '0},
		'{OP_ALLOC,  15'd0,     8'sd0,   1'b0, '0},
		'{OP_ADJUST, 15'h5555,  8'sh55,  1'b0, '0},
		'{OP_ADJUST, 15'h2AAA,  8'shAA,  1'b0, '0},
		'{OP_FREE,   15'h2AAA,  8'sd0,   1'b0, '0}
	};

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Applies one request to the private state and returns its result.
	// With 32768 pages every 15-bit page number lies inside the count store,
	// so only the first_page bound can reject a request.
	function automatic rsp_t predict_page_op(req_t r);
		rsp_t              o;
		logic [PAGE_W-1:0] got;
		o = '0;
		o.status = ST_OK;
		case (r.operation)
			OP_ALLOC: begin
				if (!model_has_free) begin
					o.status = ST_OOM;
				end else begin
					got = model_head;
					model_head = model_link[got];
					model_has_free = model_link_ok[got];
					model_count[got] = 8'sd1;
					o.granted_page = got;
					o.count = 8'sd1;
				end
			end
			OP_FREE, OP_SEED: begin
				if (r.page < model_first_page) begin
					o.status = ST_RANGE;
				end else begin
					if (r.operation == OP_SEED)
						model_count[r.page] = 8'sd1;
					model_count[r.page] = model_count[r.page] - 8'sd1;
					o.count = model_count[r.page];
					// Only an exact zero releases the page; a wrap to -1 does not.
					if (model_count[r.page] == 8'sd0) begin
						model_link[r.page] = model_head;
						model_link_ok[r.page] = model_has_free;
						model_head = r.page;
						model_has_free = 1'b1;
						o.released = 1'b1;
					end
				end
			end
			OP_ADJUST: begin
				model_count[r.page] = model_count[r.page] + r.delta;
				o.count = model_count[r.page];
			end
		endcase
		return o;
	endfunction

	// Most random requests work on a small window of managed pages so that
	// pages cycle through the list; the rest hit pages below first_page or
	// anywhere in the page space. Frees favor pages that were handed out.
	function automatic req_t make_random_request();
		req_t        r;
		int unsigned pick;
		int unsigned idx;
		int unsigned lo;
		int unsigned hi;
		int          small_delta;
		r = '0;
		lo = model_first_page;
		hi = (lo + PAGE_WINDOW - 1 > PAGE_LIMIT - 1) ? PAGE_LIMIT - 1 : lo + PAGE_WINDOW - 1;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.operation = OP_ALLOC;
		else if (pick < 60)
			r.operation = OP_FREE;
		else if (pick < 72)
			r.operation = OP_SEED;
		else
			r.operation = OP_ADJUST;
		pick = $urandom_range(0, 99);
		if (r.operation == OP_FREE && held_pages.size() != 0 && pick < 60) begin
			idx = $urandom_range(0, held_pages.size() - 1);
			r.page = held_pages[idx];
			held_pages.delete(idx);
		end else if (pick < 75) begin
			r.page = PAGE_W'($urandom_range(lo, hi));
		end else if (pick < 85 && lo != 0) begin
			r.page = PAGE_W'($urandom_range(0, lo - 1));
		end else begin
			r.page = PAGE_W'($urandom_range(0, PAGE_LIMIT - 1));
		end
		if ($urandom_range(0, 4) == 0) begin
			r.delta = COUNT_W'($urandom_range(0, 255));
		end else begin
			small_delta = int'($urandom_range(0, 4)) - 2;
			r.delta = COUNT_W'(small_delta);
		end
		return r;
	endfunction

	// Offers one request and records its expectation at the edge where the
	// transfer happens. Between bursts the sender drops push for a while.
	task automatic offer_request(req_t r, bit typed, rsp_t want);
		rsp_t        predicted;
		int unsigned gap;
		push <= 1'b1;
		request <= r;
		do @(posedge clk); while (full);
		predicted = predict_page_op(r);
		expected_results.push_back(typed ? want : predicted);
		if (r.operation == OP_ALLOC && predicted.status == ST_OK &&
				held_pages.size() < HELD_MAX)
			held_pages.push_back(predicted.granted_page);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// Now and then a long burst with no idle cycles at all.
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
			gap = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected result has been
	// transferred, then lets the back end settle.
	task automatic wait_until_idle();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes first_page over the configuration port, then reads it back.
	task automatic set_first_page(logic [PAGE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FIRST_PAGE_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model_first_page = value;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(value))
			report_mismatch($sformatf("first_page read back %0h, wrote %0h", prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_phase(int n);
		for (int i = 0; i < n; i++)
			offer_request(make_random_request(), 1'b0, '0);
	endtask

	// Compares one transferred result with the oldest expectation.
	task automatic check_result(rsp_t got);
		rsp_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result transferred with nothing expected");
			return;
		end
		want = expected_results.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.granted_page !== want.granted_page)
			report_mismatch($sformatf("granted_page %0d, expected %0d",
				got.granted_page, want.granted_page));
		if (got.count !== want.count)
			report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
		if (got.released !== want.released)
			report_mismatch($sformatf("released %0b, expected %0b", got.released, want.released));
	endtask

	// Result side. Every edge first checks a transfer that happened on it,
	// then decides pop for the next cycle. The stall pattern follows bits 9:8
	// of rx_cycle: pop always, pop at random, pop when rx_cycle is a multiple
	// of three, pop nearly always. Twice the receiver holds off for a long
	// stretch so that both internal queues fill and full stalls the sender.
	logic [31:0] rx_cycle     = '0;
	int          results_seen = 0;
	int          hold_left    = 0;

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (pop && !empty) begin
			check_result(result);
			results_seen++;
			if (results_seen == 300 || results_seen == 1100)
				hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (rx_cycle[9:8])
				2'd0: pop <= 1'b1;
				2'd1: pop <= 1'($urandom_range(0, 1));
				2'd2: pop <= (rx_cycle % 3 == 0);
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Request side and run control.
	initial begin
		foreach (model_count[i]) begin
			model_count[i] = '0;
			model_link[i] = '0;
			model_link_ok[i] = 1'b0;
		end
		model_head = '0;
		model_has_free = 1'b0;
		model_first_page = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// full stays high while the count store is swept after reset.
		do @(posedge clk); while (full);

		set_first_page(PAGE_W'(16));
		foreach (directed_steps[i])
			offer_request('{directed_steps[i].op, directed_steps[i].page,
				directed_steps[i].delta}, directed_steps[i].typed, directed_steps[i].want);
		wait_until_idle();

		// Random phases under several first_page settings, the extremes
		// among them. State carries over from one phase to the next.
		set_first_page('0);
		run_random_phase(600);
		wait_until_idle();
		set_first_page(PAGE_W'(PAGE_LIMIT - 1));
		run_random_phase(150);
		wait_until_idle();
		set_first_page(PAGE_W'($urandom_range(1, PAGE_LIMIT - 2)));
		run_random_phase(600);
		wait_until_idle();
		set_first_page(PAGE_W'(8));
		run_random_phase(600);
		wait_until_idle();

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
